### hw/rtl/mfp_pkg.sv
package mfp_pkg;

	localparam int NUM_TYPES = 10;
	localparam int MAX_FIELDS = 18;
	localparam int SLOT_W = 4;
	localparam logic [3:0] STAMP_BYTES = 4'd6;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_SHORT   = 2'd1,
		STATUS_UNKNOWN = 2'd2
	} status_t;

	// Known type letters: S R H A F E C X D U
	localparam logic [7:0] TYPE_LETTER [NUM_TYPES] = '{
		8'h53, 8'h52, 8'h48, 8'h41, 8'h46, 8'h45, 8'h43, 8'h58, 8'h44, 8'h55
	};

	localparam logic [4:0] LAYOUT_COUNT [NUM_TYPES] = '{
		5'd5, 5'd18, 5'd8, 5'd9, 5'd10, 5'd7, 5'd9, 5'd6, 5'd5, 5'd8
	};

	localparam logic [3:0] T6 = STAMP_BYTES;

	localparam logic [3:0] LAYOUT_WIDTH [NUM_TYPES][MAX_FIELDS] = '{
		'{4'd1, 4'd2, 4'd2, T6, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd1, 4'd1, 4'd4, 4'd1,
		  4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd4, 4'd1},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd1, 4'd1, 4'd4, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd1, 4'd4, 4'd8, 4'd4,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd1, 4'd4, 4'd8, 4'd4,
		  4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd4, 4'd8, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd4, 4'd8, 4'd1, 4'd4,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd4, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd2, 4'd2, T6, 4'd8, 4'd8, 4'd4, 4'd4, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
	};

	typedef struct packed {
		logic [2:0]  byte_in_field;
		logic [4:0]  field_number;
		logic [7:0]  current_type;
		logic [63:0] accumulator;
		logic        skipping;
		logic        layout_done;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  msg_type;
		logic [4:0]  field_index;
		logic [63:0] field_value;
		logic [3:0]  field_bytes;
		logic        last_field;
		status_t     status;
	} field_res_t;

	// Slot of a known letter, NUM_TYPES when unknown
	function automatic logic [SLOT_W-1:0] type_slot(input logic [7:0] t);
		logic [SLOT_W-1:0] slot;
		slot = SLOT_W'(NUM_TYPES);
		for (int i = NUM_TYPES - 1; i >= 0; i--) begin
			if (TYPE_LETTER[i] == t) begin
				slot = SLOT_W'(i);
			end
		end
		return slot;
	endfunction

endpackage

### hw/rtl/mfp_step.sv
module mfp_step (
	input  mfp_pkg::parse_state_t cur,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output mfp_pkg::parse_state_t nxt,
	output mfp_pkg::field_res_t   res
);
	import mfp_pkg::*;

	logic [7:0]        typ;
	logic [SLOT_W-1:0] slot;
	logic [4:0]        count;
	logic [3:0]        width;
	logic [63:0]       acc;
	logic              final_field;

	always_comb begin
		typ = (cur.field_number == 5'd0 && cur.byte_in_field == 3'd0) ?
			in_byte : cur.current_type;
		slot = type_slot(typ);
		count = 5'd0;
		width = 4'd0;
		if (slot < SLOT_W'(NUM_TYPES)) begin
			count = LAYOUT_COUNT[slot];
			if (cur.field_number < count) begin
				width = LAYOUT_WIDTH[slot][cur.field_number];
			end
		end
		acc = {cur.accumulator[55:0], in_byte};
		final_field = (cur.field_number + 5'd1 == count);
	end

	always_comb begin
		nxt = cur;
		res = '0;
		res.status = STATUS_OK;
		if (cur.skipping || cur.layout_done) begin
			if (in_last) begin
				nxt.skipping = 1'b0;
				nxt.layout_done = 1'b0;
				nxt.byte_in_field = '0;
				nxt.field_number = '0;
				nxt.accumulator = '0;
			end
		end else begin
			nxt.current_type = typ;
			res.msg_type = typ;
			res.field_index = cur.field_number;
			if (slot >= SLOT_W'(NUM_TYPES)) begin
				res.valid = 1'b1;
				res.status = STATUS_UNKNOWN;
				nxt.skipping = !in_last;
			end else if (cur.field_number >= count) begin
				// not reachable from reset; treat as a finished layout
				nxt.layout_done = !in_last;
			end else if ({1'b0, cur.byte_in_field} + 4'd1 < width) begin
				nxt.byte_in_field = cur.byte_in_field + 3'd1;
				nxt.accumulator = acc;
				if (in_last) begin
					res.valid = 1'b1;
					res.status = STATUS_SHORT;
				end
			end else if (in_last && !final_field) begin
				res.valid = 1'b1;
				res.status = STATUS_SHORT;
				res.field_index = cur.field_number + 5'd1;
			end else begin
				res.valid = 1'b1;
				res.field_value = acc;
				res.field_bytes = width;
				res.last_field = final_field;
				nxt.accumulator = '0;
				nxt.byte_in_field = '0;
				nxt.field_number = cur.field_number + 5'd1;
				nxt.layout_done = final_field && !in_last;
			end
			if (in_last) begin
				nxt.byte_in_field = '0;
				nxt.field_number = '0;
				nxt.accumulator = '0;
				nxt.skipping = 1'b0;
				nxt.layout_done = 1'b0;
			end
		end
	end

endmodule

### hw/rtl/market_feed_message_parser.sv
// Market-feed message parser: one message byte per input transaction.
// Input channel: in_valid/in_stall carry in_byte and in_last (last byte of
// the frame). Output channel: out_valid/out_stall carry one parsed field per
// transaction (msg_type, field_index, field_value, field_bytes, last_field,
// status), or an error with status short or unknown type.
// A byte accepted into the input register is stepped once the result
// register can take a transaction; a field it completes is registered there
// and shows on out_valid. Throughput is one byte per cycle unless out_stall
// holds a result, set by the combinational step between the two registers.
// Back pressure: the input register doubles as a skid stage, so one more byte
// is taken while a result waits; in_stall rises only when both the result
// register and the input register are full and out_stall is high.
// Bytes with no result pass the step one per cycle unless a result is stalled.
// Reset (arst_n low, asynchronous) clears the parser state, empties both
// registers and leaves the parser waiting for the type byte of a new frame.
module market_feed_message_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  msg_type,
	output logic [4:0]  field_index,
	output logic [63:0] field_value,
	output logic [3:0]  field_bytes,
	output logic        last_field,
	output logic [1:0]  status
);
	import mfp_pkg::*;

	// input register (skid stage)
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	parse_state_t state_q;
	parse_state_t state_nxt;
	field_res_t   res;

	logic advance;
	logic take_in;

	// step the held byte whenever the result register can take a transaction
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	mfp_step u_step (
		.cur     (state_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res.valid;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result payload; loaded only when a field or error is produced
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			msg_type    <= res.msg_type;
			field_index <= res.field_index;
			field_value <= res.field_value;
			field_bytes <= res.field_bytes;
			last_field  <= res.last_field;
			status      <= 2'(res.status);
		end
	end

endmodule
